### rtl/ohm_pkg.sv
// Shared types and constants for the open-addressing key/value table.
// No dependencies; every other file imports this package.
`default_nettype none

package ohm_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int TRY_W    = IDX_W + 1;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);

    localparam int OP_W     = 2;
    localparam int KEY_W    = 64;
    localparam int HASH_W   = 32;
    localparam int VALUE_W  = 64;
    localparam int ENTRY_W  = 7;

    typedef enum logic [OP_W-1:0] {
        OP_PUT = 2'd0,
        OP_DEL = 2'd1,
        OP_GET = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_CMP
    } seq_state_t;

    typedef struct packed {
        logic             start;
        logic [IDX_W-1:0] home;
        logic             advance;
        logic [KEY_W-1:0] key;
    } probe_ctrl_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             exhausted;
        logic             key_match;
    } probe_stat_t;

    typedef struct packed {
        logic               rd_en;
        logic               wr_key;
        logic               wr_value;
        logic               set_used;
        logic               clr_used;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } store_cmd_t;

    typedef struct packed {
        logic               used;
        logic [KEY_W-1:0]   key_rd;
        logic [VALUE_W-1:0] value_rd;
        logic [COUNT_W-1:0] count;
    } store_stat_t;

endpackage

`default_nettype wire

### rtl/ohm_req_if.sv
// Request channel: one table operation per item.
// Depends on ohm_pkg for field widths.
`default_nettype none

interface ohm_req_if;
    import ohm_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [KEY_W-1:0]   key;
    logic [HASH_W-1:0]  key_hash;
    logic [VALUE_W-1:0] value;

    modport source (output valid, op, key, key_hash, value, input ready);
    modport sink   (input valid, op, key, key_hash, value, output ready);
endinterface

`default_nettype wire

### rtl/ohm_rsp_if.sv
// Response channel: one result item per request.
// Depends on ohm_pkg for field widths.
`default_nettype none

interface ohm_rsp_if;
    import ohm_pkg::*;

    logic               valid;
    logic               ready;
    logic               status;
    logic               found;
    logic [VALUE_W-1:0] read_value;
    logic [ENTRY_W-1:0] entry_count;

    modport source (output valid, status, found, read_value, entry_count, input ready);
    modport sink   (input valid, status, found, read_value, entry_count, output ready);
endinterface

`default_nettype wire

### rtl/ohm_probe.sv
// Shared probe unit: triangular slot address generator and key comparator.
// Depends on ohm_pkg.
`default_nettype none

module ohm_probe (
    input  wire                 clk,
    input  wire                 rst_n,
    input  ohm_pkg::probe_ctrl_t ctrl,
    input  wire [63:0]          key_rd,
    output ohm_pkg::probe_stat_t stat
);
    import ohm_pkg::*;

    logic [IDX_W-1:0] idx_reg,   idx_next;
    logic [TRY_W-1:0] tries_reg, tries_next;

    // offset(i+1) - offset(i) = i + 1, so one adder walks the sequence
    always_comb
    begin
        idx_next   = idx_reg;
        tries_next = tries_reg;
        if (ctrl.start)
        begin
            idx_next   = ctrl.home;
            tries_next = '0;
        end
        else if (ctrl.advance)
        begin
            idx_next   = idx_reg + tries_reg[IDX_W-1:0] + IDX_W'(1);
            tries_next = tries_reg + TRY_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            tries_reg <= '0;
        end
        else
        begin
            idx_reg   <= idx_next;
            tries_reg <= tries_next;
        end
    end

    assign stat.idx       = idx_reg;
    assign stat.exhausted = (tries_reg == TRY_W'(CAPACITY));
    assign stat.key_match = (key_rd == ctrl.key);

endmodule

`default_nettype wire

### rtl/ohm_store.sv
// Slot storage: key and value memories, used bits and occupancy count.
// Depends on ohm_pkg.
`default_nettype none

module ohm_store (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire [ohm_pkg::IDX_W-1:0]    addr,
    input  ohm_pkg::store_cmd_t         cmd,
    output ohm_pkg::store_stat_t        stat
);
    import ohm_pkg::*;

    logic [KEY_W-1:0]   key_mem   [CAPACITY];
    logic [VALUE_W-1:0] value_mem [CAPACITY];
    logic [KEY_W-1:0]   key_rd_reg;
    logic [VALUE_W-1:0] value_rd_reg;
    logic [CAPACITY-1:0] used_reg;
    logic [COUNT_W-1:0]  count_reg, count_next;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_key)
        begin
            key_mem[addr] <= cmd.key;
        end
        if (cmd.rd_en)
        begin
            key_rd_reg <= key_mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_value)
        begin
            value_mem[addr] <= cmd.value;
        end
        if (cmd.rd_en)
        begin
            value_rd_reg <= value_mem[addr];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.set_used)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (cmd.clr_used)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.set_used)
            begin
                used_reg[addr] <= 1'b1;
            end
            else if (cmd.clr_used)
            begin
                used_reg[addr] <= 1'b0;
            end
            count_reg <= count_next;
        end
    end

    assign stat.used     = used_reg[addr];
    assign stat.key_rd   = key_rd_reg;
    assign stat.value_rd = value_rd_reg;
    assign stat.count    = count_reg;

endmodule

`default_nettype wire

### rtl/ohm_seq.sv
// Sequencer: takes an item, steps the probe unit, updates the store, and
// holds the result in an output register. Depends on ohm_pkg and the channel interfaces.
`default_nettype none

module ohm_seq (
    input  wire                  clk,
    input  wire                  rst_n,
    ohm_req_if.sink              req,
    ohm_rsp_if.source            rsp,
    input  ohm_pkg::probe_stat_t probe_stat,
    output ohm_pkg::probe_ctrl_t probe_ctrl,
    input  ohm_pkg::store_stat_t store_stat,
    output ohm_pkg::store_cmd_t  store_cmd
);
    import ohm_pkg::*;

    seq_state_t state_reg, state_next;

    op_t                op_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VALUE_W-1:0] value_reg;

    logic               rsp_valid_reg, rsp_valid_next;
    logic               status_reg;
    logic               found_reg;
    logic [VALUE_W-1:0] read_value_reg;
    logic [ENTRY_W-1:0] entry_count_reg;

    logic               accept;
    logic               out_free;
    logic               done;
    logic               load;
    logic               res_status;
    logic               res_found;
    logic [VALUE_W-1:0] res_value;
    logic [COUNT_W-1:0] res_count;

    assign accept   = req.valid && req.ready;
    assign out_free = !rsp_valid_reg || rsp.ready;
    assign load     = done && out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (load)
                begin
                    state_next = ST_IDLE;
                end
                else if (!done)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (load)
                begin
                    state_next = ST_IDLE;
                end
                else if (!done)
                begin
                    state_next = ST_LOOK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Side effects on the store only fire together with loading the result
    always_comb
    begin
        done       = 1'b0;
        res_status = 1'b0;
        res_found  = 1'b0;
        res_value  = '0;
        res_count  = store_stat.count;

        req.ready  = 1'b0;

        probe_ctrl.start   = 1'b0;
        probe_ctrl.home    = req.key_hash[IDX_W-1:0];
        probe_ctrl.advance = 1'b0;
        probe_ctrl.key     = key_reg;

        store_cmd.rd_en    = 1'b0;
        store_cmd.wr_key   = 1'b0;
        store_cmd.wr_value = 1'b0;
        store_cmd.set_used = 1'b0;
        store_cmd.clr_used = 1'b0;
        store_cmd.key      = key_reg;
        store_cmd.value    = value_reg;

        case (state_reg)
            ST_IDLE:
            begin
                req.ready        = 1'b1;
                probe_ctrl.start = req.valid;
            end
            ST_LOOK:
            begin
                if (!(op_reg inside {OP_PUT, OP_DEL, OP_GET}))
                begin
                    done = 1'b1;
                end
                else if (probe_stat.exhausted)
                begin
                    done       = 1'b1;
                    res_status = 1'b1;
                end
                else if (!store_stat.used)
                begin
                    done = 1'b1;
                    if (op_reg == OP_PUT)
                    begin
                        store_cmd.wr_key   = out_free;
                        store_cmd.wr_value = out_free;
                        store_cmd.set_used = out_free;
                        res_count          = store_stat.count + COUNT_W'(1);
                    end
                end
                else
                begin
                    store_cmd.rd_en = 1'b1;
                end
            end
            ST_CMP:
            begin
                if (probe_stat.key_match)
                begin
                    done      = 1'b1;
                    res_found = 1'b1;
                    case (op_reg)
                        OP_PUT:
                        begin
                            store_cmd.wr_value = out_free;
                        end
                        OP_DEL:
                        begin
                            store_cmd.clr_used = out_free;
                            res_count          = store_stat.count - COUNT_W'(1);
                        end
                        default:
                        begin
                            res_value = store_stat.value_rd;
                        end
                    endcase
                end
                else
                begin
                    probe_ctrl.advance = 1'b1;
                end
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op_t'(req.op);
            key_reg   <= req.key;
            value_reg <= req.value;
        end
        if (load)
        begin
            status_reg      <= res_status;
            found_reg       <= res_found;
            read_value_reg  <= res_value;
            entry_count_reg <= ENTRY_W'(res_count);
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.found       = found_reg;
    assign rsp.read_value  = read_value_reg;
    assign rsp.entry_count = entry_count_reg;

endmodule

`default_nettype wire

### rtl/open_addressing_hash_map.sv
// Open-addressing key/value table with triangular probing, 64 slots.
//
// req channel: one item per operation (op 0 put, 1 delete, 2 get) with key,
// key_hash and value. Slot (key_hash + i(i+1)/2) mod 64 is probed for
// i = 0, 1, ... until a free slot or an equal key turns up or all 64 are tried.
// rsp channel: one item per request with status (1 = table full), found,
// read_value (get hit only, else 0) and entry_count after the operation.
//
// Timing: each probe of an occupied slot passes through ST_LOOK, which reads
// the key memory, and then ST_CMP, which uses the shared comparator and adder.
// The result loads from ST_LOOK when the probed slot is free or all slots are
// tried, and from ST_CMP on a hit; each occupied slot passed adds another
// ST_LOOK and ST_CMP. req.ready is high only between items, so an item is not
// taken before the last one has loaded its result; op 3 changes nothing.
//
// Results sit in an output register; the next item is accepted while it
// waits. If rsp stalls, the next item waits at its final probe, with no
// store update, until the register frees.
// Reset empties the table at once through the used bits; no clearing pass.
`default_nettype none

module open_addressing_hash_map (
    input  wire        clk,
    input  wire        rst_n,
    ohm_req_if.sink    req,
    ohm_rsp_if.source  rsp
);
    import ohm_pkg::*;

    probe_ctrl_t probe_ctrl;
    probe_stat_t probe_stat;
    store_cmd_t  store_cmd;
    store_stat_t store_stat;

    ohm_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .probe_stat (probe_stat),
        .probe_ctrl (probe_ctrl),
        .store_stat (store_stat),
        .store_cmd  (store_cmd)
    );

    ohm_probe u_probe (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (probe_ctrl),
        .key_rd (store_stat.key_rd),
        .stat   (probe_stat)
    );

    ohm_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .addr  (probe_stat.idx),
        .cmd   (store_cmd),
        .stat  (store_stat)
    );

endmodule

`default_nettype wire

### rtl/ohm_checker.sv
// Port-level checks on the table's result channel, bound to the top level.
// Depends on ohm_pkg.
`default_nettype none

module ohm_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        rsp_valid,
    input wire        rsp_ready,
    input wire        status,
    input wire        found,
    input wire [63:0] read_value,
    input wire [6:0]  entry_count
);
    import ohm_pkg::*;

    // a full table never reports a hit
    a_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status |-> !found)
        else $error("full result with found set");

    // read data only accompanies a hit
    a_value_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (read_value != '0) |-> found)
        else $error("read_value without found");

    // occupancy stays within the table
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (entry_count <= ENTRY_W'(CAPACITY)))
        else $error("entry_count above capacity");

    // a stalled result stays valid with entry_count and found held
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(entry_count) && $stable(found))
        else $error("stalled result changed");

endmodule

bind open_addressing_hash_map ohm_checker u_ohm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (rsp.status),
    .found       (rsp.found),
    .read_value  (rsp.read_value),
    .entry_count (rsp.entry_count)
);

`default_nettype wire
